[design/lru_pkg.sv]
// Shared types and constants for the LRU page replacement block.
// No dependencies; used by lru_page_replacement.
`default_nettype none

package lru_pkg;

    localparam int unsigned STAMP_W    = 32;
    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 16;

    localparam logic [STAMP_W-1:0] TICK_MAX = '1;

    // Result action codes
    typedef enum logic [1:0] {
        ACT_NONE      = 2'd0,
        ACT_PAGE_IN   = 2'd1,
        ACT_PAGE_OUT  = 2'd2,
        ACT_NO_VICTIM = 2'd3
    } t_action;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_FIX,
        ST_DECIDE,
        ST_SCAN,
        ST_FINISH,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

[design/lru_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module lru_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[design/lru_page_replacement.sv]
// Top level of the LRU page replacement block: sequencer, divider-free page
// lookup and stamp scan. Depends on lru_pkg and lru_ram.
`default_nettype none

// Per-process least-recently-used pager. A tick transfer (tuser = 1) bumps a
// saturating 32-bit tick counter. An access transfer (tuser = 0) looks up the
// wanted page (pc / PAGE_SIZE); a resident page is stamped with the tick, a
// missing page with a free frame is stamped and requested for page-in, and
// otherwise the resident page with the oldest stamp (lowest page on ties,
// wanted page excluded, scan limited to page_count) is named for page-out, or
// "no victim" is reported. Exactly one result transfer follows every input
// transfer. After reset the stamp memory is swept to zero, one entry per cycle,
// with s_axis_tready low. One item is in work at a time; a page-out search
// walks min(page_count, PAGES_PER_PROCESS) entries, paced by the single read
// port of the stamp memory (one stamp per cycle through one shared compare).
// A finished result sits in the output register, so the next item may be
// taken while it waits.
module lru_page_replacement #(
    parameter int PROCESS_COUNT     = 32,
    parameter int PAGES_PER_PROCESS = 32,
    parameter int PAGE_SIZE         = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [4:0] process, [5] active, [17:6] pc, [49:18] resident_mask,
    // [55:50] page_count, [56] frame_free, [63:57] zero
    input  wire logic [63:0] s_axis_tdata,
    // [0] mode
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [1:0] action, [6:2] out_process, [11:7] page, [15:12] zero
    output logic [15:0]      m_axis_tdata
);

    localparam int DEPTH = PROCESS_COUNT * PAGES_PER_PROCESS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = $clog2(PAGES_PER_PROCESS);     // page index
    localparam int IW    = $clog2(PAGES_PER_PROCESS + 1); // scan counter
    // Reciprocal for pc / PAGE_SIZE; estimate is low by at most one
    localparam logic [31:0] RECIP = 32'((1 << 24) / PAGE_SIZE);

    // Control state
    lru_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_clr;
    logic [lru_pkg::STAMP_W-1:0] r_tick;
    logic            r_m_valid;

    // Item payload
    logic [4:0]      r_proc;
    logic            r_active;
    logic [11:0]     r_pc;
    logic [PAGES_PER_PROCESS-1:0] r_mask;
    logic [5:0]      r_count;
    logic            r_ffree;

    // Working registers
    logic [7:0]      r_q;
    logic [8:0]      r_want;
    logic [IW-1:0]   r_idx;
    logic [IW-1:0]   r_limit;
    logic            r_pend;
    logic [PW-1:0]   r_pend_page;
    logic            r_found;
    logic [PW-1:0]   r_best_page;
    logic [lru_pkg::STAMP_W-1:0] r_best_stamp;
    lru_pkg::t_action r_res_action;
    logic [4:0]      r_res_proc;
    logic [4:0]      r_res_page;
    logic [15:0]     r_m_data;

    // Datapath wires
    logic [31:0]     w_prod;
    logic [8:0]      w_q_inc;
    logic [23:0]     w_bound;
    logic            w_proc_ok;
    logic            w_want_ok;
    logic            w_hit;
    logic            w_cand;
    logic            w_scan_end;
    logic            w_out_free;
    logic            w_accept;
    logic [AW:0]     w_base;

    // Memory port
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [lru_pkg::STAMP_W-1:0] w_wdata;
    logic [AW-1:0]   w_raddr;
    logic [lru_pkg::STAMP_W-1:0] w_rdata;

    lru_ram #(
        .WIDTH (lru_pkg::STAMP_W),
        .DEPTH (DEPTH)
    ) u_stamp (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;

    // Page number: multiply by reciprocal, then one correction step
    assign w_prod  = 32'(r_pc) * RECIP;
    assign w_q_inc = {1'b0, r_q} + 9'd1;
    assign w_bound = 24'(w_q_inc) * 24'(PAGE_SIZE);

    assign w_proc_ok = r_active && ({2'b00, r_proc} < 7'(PROCESS_COUNT));
    assign w_want_ok = r_want < 9'(PAGES_PER_PROCESS);
    assign w_hit     = r_mask[r_want[PW-1:0]];
    assign w_base    = (AW+1)'(r_proc) * (AW+1)'(PAGES_PER_PROCESS);

    // Scan candidate: in range, resident, not the wanted page
    assign w_cand     = (r_idx < r_limit) && r_mask[r_idx[PW-1:0]]
                        && (9'(r_idx) != r_want);
    assign w_scan_end = (r_idx >= r_limit) && !r_pend;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lru_pkg::ST_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) n_state = lru_pkg::ST_IDLE;
            end
            lru_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = s_axis_tuser ? lru_pkg::ST_DONE : lru_pkg::ST_DIV;
                end
            end
            lru_pkg::ST_DIV:    n_state = lru_pkg::ST_FIX;
            lru_pkg::ST_FIX:    n_state = lru_pkg::ST_DECIDE;
            lru_pkg::ST_DECIDE: begin
                if (!w_proc_ok || !w_want_ok || w_hit || r_ffree) begin
                    n_state = lru_pkg::ST_DONE;
                end else begin
                    n_state = lru_pkg::ST_SCAN;
                end
            end
            lru_pkg::ST_SCAN: begin
                if (w_scan_end) n_state = lru_pkg::ST_FINISH;
            end
            lru_pkg::ST_FINISH: n_state = lru_pkg::ST_DONE;
            lru_pkg::ST_DONE: begin
                if (w_out_free) n_state = lru_pkg::ST_IDLE;
            end
            default: n_state = lru_pkg::ST_CLEAR;
        endcase
    end

    // Handshake and memory controls
    always_comb begin
        s_axis_tready = 1'b0;
        w_we          = 1'b0;
        w_waddr       = AW'(w_base + (AW+1)'(r_want[PW-1:0]));
        w_wdata       = r_tick;
        w_raddr       = AW'(w_base + (AW+1)'(r_idx));
        case (r_state)
            lru_pkg::ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
            end
            lru_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            lru_pkg::ST_DECIDE: begin
                w_we = w_proc_ok && w_want_ok && (w_hit || r_ffree);
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lru_pkg::ST_CLEAR;
            r_clr     <= '0;
            r_tick    <= lru_pkg::STAMP_W'(1);
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == lru_pkg::ST_CLEAR) r_clr <= r_clr + AW'(1);
            if (w_accept && s_axis_tuser && (r_tick != lru_pkg::TICK_MAX)) begin
                r_tick <= r_tick + lru_pkg::STAMP_W'(1);
            end
            if (r_state == lru_pkg::ST_DONE && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            lru_pkg::ST_IDLE: begin
                if (w_accept) begin
                    r_proc       <= s_axis_tdata[4:0];
                    r_active     <= s_axis_tdata[5];
                    r_pc         <= s_axis_tdata[17:6];
                    r_mask       <= s_axis_tdata[18 +: PAGES_PER_PROCESS];
                    r_count      <= s_axis_tdata[55:50];
                    r_ffree      <= s_axis_tdata[56];
                    // tick result is fixed
                    r_res_action <= lru_pkg::ACT_NONE;
                    r_res_proc   <= '0;
                    r_res_page   <= '0;
                end
            end
            lru_pkg::ST_DIV: begin
                r_q <= w_prod[31:24];
            end
            lru_pkg::ST_FIX: begin
                r_want <= (24'(r_pc) >= w_bound) ? w_q_inc : {1'b0, r_q};
            end
            lru_pkg::ST_DECIDE: begin
                r_res_proc   <= r_proc;
                r_res_action <= lru_pkg::ACT_NONE;
                r_res_page   <= '0;
                if (w_proc_ok && w_want_ok) begin
                    if (w_hit) begin
                        r_res_page <= 5'(r_want);
                    end else if (r_ffree) begin
                        r_res_action <= lru_pkg::ACT_PAGE_IN;
                        r_res_page   <= 5'(r_want);
                    end
                end
                r_limit <= ({1'b0, r_count} < 7'(PAGES_PER_PROCESS))
                           ? IW'(r_count) : IW'(PAGES_PER_PROCESS);
                r_idx   <= '0;
                r_pend  <= 1'b0;
                r_found <= 1'b0;
            end
            lru_pkg::ST_SCAN: begin
                // compare the stamp read last cycle; strict < keeps lowest page
                if (r_pend && (!r_found || (w_rdata < r_best_stamp))) begin
                    r_found      <= 1'b1;
                    r_best_stamp <= w_rdata;
                    r_best_page  <= r_pend_page;
                end
                r_pend      <= w_cand;
                r_pend_page <= r_idx[PW-1:0];
                if (r_idx < r_limit) r_idx <= r_idx + IW'(1);
            end
            lru_pkg::ST_FINISH: begin
                r_res_action <= r_found ? lru_pkg::ACT_PAGE_OUT : lru_pkg::ACT_NO_VICTIM;
                r_res_page   <= r_found ? 5'(r_best_page) : 5'd0;
            end
            lru_pkg::ST_DONE: begin
                if (w_out_free) begin
                    r_m_data <= {4'b0000, r_res_page, r_res_proc, r_res_action};
                end
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

`ifndef SYNTHESIS
    // Scan counter never runs past the limit
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lru_pkg::ST_SCAN) |-> (r_idx <= r_limit))
        else $error("scan index past limit");

    // A chosen victim is resident and is not the wanted page
    a_victim_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lru_pkg::ST_FINISH && r_found) |->
        (r_mask[r_best_page] && (9'(r_best_page) != r_want)))
        else $error("victim not a valid candidate");

    // Stamps are never written during a search
    a_no_write_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lru_pkg::ST_SCAN || r_state == lru_pkg::ST_FINISH) |-> !w_we)
        else $error("stamp write during scan");

    // No input is taken before the stamp memory is cleared
    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lru_pkg::ST_CLEAR) |=> !$past(w_accept))
        else $error("input taken during clear");
`endif

endmodule

`default_nettype wire

[tb/tb_lru_page_replacement.sv]
// Self-checking testbench for lru_page_replacement: stream stimulus, a cycle-free
// predictor of the per-process LRU pager and an in-order result checker.
// Depends on lru_pkg and the design sources only.
`default_nettype none

module tb_lru_page_replacement;

    timeunit 1ns;
    timeprecision 1ps;

    // Same sizes as the instance below
    localparam int unsigned NPROC   = 32;
    localparam int unsigned NPAGES  = 32;
    localparam int unsigned PG_SIZE = 128;

    // One access or tick item as it travels on the slave side
    typedef struct {
        logic        mode;          // 1 = advance the tick
        logic [4:0]  proc_id;
        logic        active;
        logic [11:0] pc;
        logic [31:0] resident;
        logic [5:0]  page_count;
        logic        frame_free;
    } t_request;

    // One pager decision as it travels on the master side
    typedef struct {
        lru_pkg::t_action action;
        logic [4:0] proc_id;
        logic [4:0] page;
    } t_decision;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    lru_page_replacement #(
        .PROCESS_COUNT    (NPROC),
        .PAGES_PER_PROCESS(NPAGES),
        .PAGE_SIZE        (PG_SIZE)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state: our own copy of the stamp store and the tick counter
    logic [31:0] stamp_copy [NPROC*NPAGES];
    logic [31:0] tick_copy;

    // Decisions predicted at input transfer time, oldest first
    t_decision pager_replies_due[$];
    int unsigned mismatch_count = 0;

    // Sender pacing: bursts of random length, random gaps in between
    bit gaps_on = 1'b1;
    int burst_left = 0;

    // Receiver pacing: stall style is redrawn at random; a test can
    // ask for one long hold-off, which the receiver counts down on its own
    int hold_request = 0;
    int hold_left = 0;
    int stall_style = 0;
    int style_left = 0;
    int unsigned stall_phase = 0;

    // ------------------------------------------------------------------
    // Predictor. Works on one accepted item and updates the copied state.
    // ------------------------------------------------------------------
    function automatic t_decision decide_replacement(t_request r);
        t_decision d;
        int unsigned want;
        int unsigned base;
        int unsigned limit;
        int unsigned i;
        bit found;
        logic [31:0] best_stamp;
        logic [4:0] best_page;
        d.action  = lru_pkg::ACT_NONE;
        d.proc_id = r.proc_id;
        d.page    = '0;
        found      = 1'b0;
        best_stamp = '0;
        best_page  = '0;
        // Tick: saturating bump, result carries no process
        if (r.mode) begin
            if (tick_copy != lru_pkg::TICK_MAX)
                tick_copy++;
            d.proc_id = '0;
            return d;
        end
        // Dead or nonexistent process: nothing happens
        if (!r.active || r.proc_id >= NPROC)
            return d;
        want = r.pc / PG_SIZE;
        if (want >= NPAGES)
            return d;
        base = r.proc_id * NPAGES;
        // Hit: stamp with the current tick
        if (r.resident[want]) begin
            stamp_copy[base + want] = tick_copy;
            d.page = 5'(want);
            return d;
        end
        // Miss with a free frame: page in and stamp
        if (r.frame_free) begin
            stamp_copy[base + want] = tick_copy;
            d.action = lru_pkg::ACT_PAGE_IN;
            d.page   = 5'(want);
            return d;
        end
        // Miss, no frame: oldest resident page below the clipped count,
        // lowest page number on equal stamps, wanted page never a victim
        limit = (r.page_count < NPAGES) ? r.page_count : NPAGES;
        for (i = 0; i < limit; i++) begin
            if (i != want && r.resident[i]) begin
                if (!found || stamp_copy[base + i] < best_stamp) begin
                    found      = 1'b1;
                    best_stamp = stamp_copy[base + i];
                    best_page  = 5'(i);
                end
            end
        end
        if (found) begin
            d.action = lru_pkg::ACT_PAGE_OUT;
            d.page   = best_page;
        end else begin
            d.action = lru_pkg::ACT_NO_VICTIM;
        end
        return d;
    endfunction

    // Active access to one process
    function automatic t_request make_access(logic [4:0] proc_id, logic [11:0] pc,
                                             logic [31:0] resident, logic [5:0] page_count,
                                             logic frame_free);
        t_request r;
        r.mode       = 1'b0;
        r.proc_id    = proc_id;
        r.active     = 1'b1;
        r.pc         = pc;
        r.resident   = resident;
        r.page_count = page_count;
        r.frame_free = frame_free;
        return r;
    endfunction

    // Access with every field random (noise)
    function automatic t_request random_request();
        t_request r;
        r.mode       = 1'b0;
        r.proc_id    = 5'($urandom);
        r.active     = 1'($urandom);
        r.pc         = 12'($urandom);
        r.resident   = $urandom;
        r.page_count = 6'($urandom_range(0, 63));
        r.frame_free = 1'($urandom);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Send one item. Drives at the falling edge, takes the transfer at the
    // rising edge where tready is high, and predicts the decision there.
    // tvalid stays high on return; the next call or stop_sending moves it.
    // ------------------------------------------------------------------
    task automatic send_item(input t_request r, output t_decision d);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.mode;
        s_axis_tdata  <= {7'd0, r.frame_free, r.page_count, r.resident, r.pc,
                          r.active, r.proc_id};
        do @(posedge i_clk); while (!s_axis_tready);
        d = decide_replacement(r);
        pager_replies_due.push_back(d);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver stall pattern
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left  = $urandom_range(20, 150);
        end
        style_left--;
        stall_phase++;
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (stall_style)
                0: begin
                    m_axis_tready <= 1'b1;
                end
                1: begin
                    m_axis_tready <= ($urandom_range(0, 2) != 0);
                end
                2: begin
                    m_axis_tready <= (stall_phase % 5 != 0);
                end
                default: begin
                    m_axis_tready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every master-side transfer against the oldest
    // prediction, field by field
    // ------------------------------------------------------------------
    t_decision due_reply;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pager_replies_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with nothing pending: action %0d process %0d page %0d",
                             $time, m_axis_tdata[1:0], m_axis_tdata[6:2], m_axis_tdata[11:7]);
            end else begin
                due_reply = pager_replies_due.pop_front();
                if (due_reply.action !== lru_pkg::t_action'(m_axis_tdata[1:0]) ||
                    due_reply.proc_id !== m_axis_tdata[6:2] ||
                    due_reply.page !== m_axis_tdata[11:7]) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: mismatch: expected action %0d process %0d page %0d, ",
                                  "got action %0d process %0d page %0d"}, $time,
                                 due_reply.action, due_reply.proc_id, due_reply.page,
                                 m_axis_tdata[1:0], m_axis_tdata[6:2], m_axis_tdata[11:7]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed: field extremes, every action, ties, count clipping,
    // dead processes, ticks
    // ------------------------------------------------------------------
    task automatic test_directed_edges();
        t_request r;
        t_decision d;
        // Tick with every other field at ones; they must not matter
        r = make_access(5'd31, 12'hFFF, '1, 6'd63, 1'b1);
        r.mode = 1'b1;
        send_item(r, d);
        // Dead process, all other fields high but the resident mask
        r = make_access(5'd31, 12'hFFF, '0, 6'd63, 1'b1);
        r.active = 1'b0;
        send_item(r, d);
        // Hit on page 0 of process 0
        send_item(make_access(5'd0, 12'd0, 32'h1, 6'd32, 1'b0), d);
        // Page-in of the topmost page of the topmost process
        send_item(make_access(5'd31, 12'hFFF, '0, 6'd32, 1'b1), d);
        // No victim: nothing resident
        send_item(make_access(5'd1, 12'd0, '0, 6'd32, 1'b0), d);
        // No victim: residents only above the page count
        send_item(make_access(5'd1, 12'd0, 32'hFFFF_0000, 6'd16, 1'b0), d);
        // No victim: page count zero
        send_item(make_access(5'd1, 12'd640, ~32'h20, 6'd0, 1'b0), d);
        // All stamps equal: lowest page wins
        send_item(make_access(5'd2, 12'd0, 32'hFFFF_FFFE, 6'd32, 1'b0), d);
        r.mode = 1'b1;
        send_item(r, d);
        // Touch page 1, then it is no longer the oldest
        send_item(make_access(5'd2, 12'd133, 32'hFFFF_FFFE, 6'd32, 1'b0), d);
        send_item(make_access(5'd2, 12'd0, 32'hFFFF_FFFE, 6'd32, 1'b0), d);
        // Oversized and just-oversized counts clip to the page range
        send_item(make_access(5'd2, 12'd0, 32'h8000_0002, 6'd63, 1'b0), d);
        send_item(make_access(5'd2, 12'd0, 32'h8000_0002, 6'd33, 1'b0), d);
        // Count 31 hides page 31
        send_item(make_access(5'd2, 12'd0, 32'h8000_0002, 6'd31, 1'b0), d);
        // Top page wanted, everything else resident
        send_item(make_access(5'd3, 12'hFFF, 32'h7FFF_FFFF, 6'd32, 1'b0), d);
        send_item(make_access(5'd3, 12'hFFF, 32'h7FFF_FFFF, 6'd32, 1'b1), d);
        r.mode = 1'b1;
        send_item(r, d);
        send_item(make_access(5'd3, 12'd0, 32'hFFFF_FFFF, 6'd32, 1'b0), d);
        send_item(make_access(5'd3, 12'd1280, 32'hFFFF_FBFF, 6'd32, 1'b0), d);
        // Dead process 0 with a hit pattern: still nothing
        r = make_access(5'd0, 12'd0, '1, 6'd32, 1'b1);
        r.active = 1'b0;
        send_item(r, d);
    endtask

    // ------------------------------------------------------------------
    // Random: mostly a small OS that keeps its own resident sets and reacts
    // to the pager's decisions, mixed with ticks and noise
    // ------------------------------------------------------------------
    task automatic test_random_traffic(input int n_items);
        t_request r;
        t_decision d;
        logic [31:0] os_resident [NPROC];
        logic [5:0] os_pages [NPROC];
        int unsigned hot_proc [4];
        int unsigned roll;
        int unsigned want;
        bit shaped;
        for (int p = 0; p < NPROC; p++) begin
            os_pages[p]    = 6'($urandom_range(2, 32));
            os_resident[p] = $urandom & 32'((64'd1 << os_pages[p]) - 64'd1);
        end
        for (int k = 0; k < 4; k++)
            hot_proc[k] = $urandom_range(0, NPROC - 1);
        for (int k = 0; k < n_items; k++) begin
            // Some stretches run with no sender gaps at all
            if (k % 100 == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            roll   = $urandom_range(0, 99);
            shaped = 1'b0;
            r      = random_request();
            if (roll < 20) begin
                r.mode = 1'b1;
            end else if (roll >= 30) begin
                shaped    = 1'b1;
                r.proc_id = ($urandom_range(0, 4) != 0) ? 5'(hot_proc[$urandom_range(0, 3)])
                                                        : 5'($urandom);
                r.active  = 1'b1;
                want      = ($urandom_range(0, 9) != 0)
                            ? $urandom_range(0, os_pages[r.proc_id] - 1)
                            : $urandom_range(0, NPAGES - 1);
                r.pc      = 12'(want * PG_SIZE + $urandom_range(0, PG_SIZE - 1));
                r.resident   = os_resident[r.proc_id];
                r.page_count = ($urandom_range(0, 9) != 0) ? os_pages[r.proc_id]
                                                           : 6'($urandom_range(0, 63));
                r.frame_free = ($urandom_range(0, 2) == 0);
            end
            send_item(r, d);
            if (shaped) begin
                if (d.action == lru_pkg::ACT_PAGE_IN)
                    os_resident[r.proc_id][d.page] = 1'b1;
                else if (d.action == lru_pkg::ACT_PAGE_OUT)
                    os_resident[r.proc_id][d.page] = 1'b0;
            end
        end
        gaps_on = 1'b1;
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // so the block fills and drops s_axis_tready
    task automatic test_backpressure();
        t_request r;
        t_decision d;
        gaps_on = 1'b0;
        @(posedge i_clk);
        hold_request = 400;
        repeat (20) begin
            r = random_request();
            r.active = 1'b1;
            r.frame_free = 1'($urandom_range(0, 2) == 0);
            send_item(r, d);
        end
        gaps_on = 1'b1;
    endtask

    // Sender goes quiet until every pending decision has come back
    task automatic test_drain_pause();
        t_request r;
        t_decision d;
        repeat (10) begin
            r = random_request();
            send_item(r, d);
        end
        stop_sending();
        while (pager_replies_due.size() != 0)
            @(posedge i_clk);
        repeat (10) begin
            r = random_request();
            r.active = 1'b1;
            send_item(r, d);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence. The block sweeps its stamp store after reset with tready
    // low; the first send simply waits for it.
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < NPROC * NPAGES; i++)
            stamp_copy[i] = '0;
        tick_copy = 32'd1;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_random_traffic(500);
        test_backpressure();
        test_drain_pause();
        stop_sending();

        while (pager_replies_due.size() != 0)
            @(posedge i_clk);
        // Give the block room for stray results to show up
        repeat (100) @(posedge i_clk);

        if (mismatch_count == 0 && pager_replies_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hang guard: far beyond the slowest legal run
    initial begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
design/lru_pkg.sv
design/lru_ram.sv
design/lru_page_replacement.sv
tb/tb_lru_page_replacement.sv
